// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the scanner's token queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JTS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define JTS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/jts_pkg.sv =====
// Shared types and constants for the JSON token scanner.
package jts_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int MAX_TOKENS   = 3;
    localparam int FIFO_DEPTH   = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] row;
        logic [31:0] column;
        logic        last;
    } t_token;

endpackage

// ===== rtl/core/jts_scan.sv =====
// Scanner state and per-byte token logic.
module jts_scan import jts_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [7:0]  i_byte,
    input  logic        i_fin,
    output logic [1:0]  o_push_n,
    output t_token      o_tok [MAX_TOKENS]
);

    localparam int PB = POSITION_BITS;

    localparam logic [3:0] K_LBRACE   = 4'd0;
    localparam logic [3:0] K_RBRACE   = 4'd1;
    localparam logic [3:0] K_COLON    = 4'd2;
    localparam logic [3:0] K_LBRACKET = 4'd3;
    localparam logic [3:0] K_RBRACKET = 4'd4;
    localparam logic [3:0] K_COMMA    = 4'd5;
    localparam logic [3:0] K_QUOTED   = 4'd6;
    localparam logic [3:0] K_WORD     = 4'd7;
    localparam logic [3:0] K_NUMBER   = 4'd8;
    localparam logic [3:0] K_FLOAT    = 4'd9;
    localparam logic [3:0] K_END      = 4'd10;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_NL       = 8'h0A;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_STR  = 3'd1,
        S_ESC  = 3'd2,
        S_WORD = 3'd3,
        S_NUM  = 3'd4
    } t_mode;

    t_mode           r_mode, n_mode;
    logic            r_fs, n_fs;
    logic [PB-1:0]   r_so, n_so;
    logic [PB-1:0]   r_bp, n_bp;
    logic [PB-1:0]   r_row, n_row;
    logic [PB-1:0]   r_col, n_col;
    logic [PB-1:0]   len;
    logic [1:0]      cnt;
    logic            handled;
    logic            opened;
    t_token          tok [MAX_TOKENS];

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h0A, 8'h0D, 8'h09, 8'h0B, 8'h0C};
    endfunction

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == '1) ? v : v + PB'(1);
    endfunction

    function automatic logic [31:0] to32(input logic [PB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    function automatic t_token mk(input logic [3:0] k, input logic [PB-1:0] s,
                                  input logic [PB-1:0] l, input logic [PB-1:0] r,
                                  input logic [PB-1:0] c);
        t_token t;
        t.kind   = k;
        t.start  = to32(s);
        t.length = to32(l);
        t.row    = to32(r);
        t.column = to32(c);
        t.last   = 1'b0;
        return t;
    endfunction

    always_comb begin
        n_mode  = r_mode;
        n_fs    = r_fs;
        n_so    = r_so;
        n_bp    = r_bp;
        n_row   = r_row;
        n_col   = r_col;
        cnt     = 2'd0;
        handled = 1'b0;
        opened  = 1'b0;
        len     = '0;
        for (int k = 0; k < MAX_TOKENS; k++) begin
            tok[k] = '0;
        end

        // pending literal or string
        case (r_mode)
            S_WORD: begin
                if (is_alnum(i_byte)) begin
                    n_bp = sat_inc(n_bp);
                    n_col = sat_inc(n_col);
                    handled = 1'b1;
                end else begin
                    len = n_bp - n_so;
                    tok[cnt] = mk(K_WORD, n_so, len, n_row, n_col - len);
                    cnt = cnt + 2'd1;
                    n_mode = S_IDLE;
                    n_fs = 1'b0;
                end
            end
            S_NUM: begin
                if (is_xdigit(i_byte) || i_byte == CH_DOT || i_byte == CH_PLUS ||
                    i_byte == CH_MINUS) begin
                    if (i_byte == CH_DOT) begin
                        n_fs = 1'b1;
                    end
                    n_bp = sat_inc(n_bp);
                    n_col = sat_inc(n_col);
                    handled = 1'b1;
                end else begin
                    len = n_bp - n_so;
                    tok[cnt] = mk(n_fs ? K_FLOAT : K_NUMBER, n_so, len, n_row, n_col - len);
                    cnt = cnt + 2'd1;
                    n_mode = S_IDLE;
                    n_fs = 1'b0;
                end
            end
            S_ESC: begin
                n_mode = S_STR;
                n_bp = sat_inc(n_bp);
                n_col = sat_inc(n_col);
                handled = 1'b1;
            end
            S_STR: begin
                if (i_byte == CH_NL) begin
                    n_row = sat_inc(n_row);
                end
                if (i_byte == CH_BSLASH) begin
                    n_mode = S_ESC;
                end else if (i_byte == CH_QUOTE) begin
                    len = n_bp - n_so;
                    tok[cnt] = mk(K_QUOTED, n_so, len, n_row, n_col - len - PB'(1));
                    cnt = cnt + 2'd1;
                    n_mode = S_IDLE;
                end
                n_bp = sat_inc(n_bp);
                n_col = sat_inc(n_col);
                handled = 1'b1;
            end
            default: begin
                n_mode = S_IDLE;
            end
        endcase

        // byte between tokens
        if (!handled) begin
            case (i_byte)
                CH_LBRACE, CH_RBRACE, CH_COLON, CH_LBRACKET, CH_RBRACKET, CH_COMMA: begin
                    case (i_byte)
                        CH_LBRACE:   tok[cnt] = mk(K_LBRACE, n_bp, PB'(1), n_row, n_col);
                        CH_RBRACE:   tok[cnt] = mk(K_RBRACE, n_bp, PB'(1), n_row, n_col);
                        CH_COLON:    tok[cnt] = mk(K_COLON, n_bp, PB'(1), n_row, n_col);
                        CH_LBRACKET: tok[cnt] = mk(K_LBRACKET, n_bp, PB'(1), n_row, n_col);
                        CH_RBRACKET: tok[cnt] = mk(K_RBRACKET, n_bp, PB'(1), n_row, n_col);
                        default:     tok[cnt] = mk(K_COMMA, n_bp, PB'(1), n_row, n_col);
                    endcase
                    cnt = cnt + 2'd1;
                    n_bp = sat_inc(n_bp);
                    n_col = sat_inc(n_col);
                end
                CH_QUOTE: begin
                    n_bp = sat_inc(n_bp);
                    n_col = sat_inc(n_col);
                    n_so = n_bp;
                    n_mode = S_STR;
                    opened = 1'b1;
                end
                default: begin
                    if (is_space(i_byte)) begin
                        if (i_byte == CH_NL) begin
                            n_row = sat_inc(n_row);
                            n_col = '0;
                        end
                    end else if (is_digit(i_byte) || i_byte == CH_PLUS ||
                                 i_byte == CH_MINUS) begin
                        n_so = n_bp;
                        n_fs = 1'b0;
                        n_mode = S_NUM;
                    end else if (is_alnum(i_byte)) begin
                        n_so = n_bp;
                        n_mode = S_WORD;
                    end else begin
                        // stray byte: empty word at its own offset
                        tok[cnt] = mk(K_WORD, n_bp, '0, n_row, n_col);
                        cnt = cnt + 2'd1;
                    end
                    n_bp = sat_inc(n_bp);
                    n_col = sat_inc(n_col);
                end
            endcase
        end

        // end of document: flush, end token, back to reset state
        if (i_fin) begin
            if (n_mode == S_WORD || n_mode == S_NUM) begin
                len = n_bp - n_so;
                tok[cnt] = mk((n_mode == S_NUM) ? (n_fs ? K_FLOAT : K_NUMBER) : K_WORD,
                              n_so, len, n_row, n_col - len);
                cnt = cnt + 2'd1;
            end else if ((n_mode == S_STR || n_mode == S_ESC) && !opened) begin
                len = n_bp - n_so;
                tok[cnt] = mk(K_QUOTED, n_so, len, n_row, n_col - len - PB'(1));
                cnt = cnt + 2'd1;
            end
            tok[cnt] = mk(K_END, n_bp, '0, n_row, n_col);
            cnt = cnt + 2'd1;
            n_mode = S_IDLE;
            n_fs = 1'b0;
            n_so = '0;
            n_bp = '0;
            n_row = '0;
            n_col = '0;
        end

        if (cnt != 2'd0) begin
            tok[cnt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
            r_fs   <= 1'b0;
            r_so   <= '0;
            r_bp   <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_go) begin
            r_mode <= n_mode;
            r_fs   <= n_fs;
            r_so   <= n_so;
            r_bp   <= n_bp;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    assign o_push_n = i_go ? cnt : 2'd0;
    assign o_tok    = tok;

endmodule

// ===== rtl/core/jts_tok_fifo.sv =====
// Token queue: takes up to three tokens a cycle while it has room, releases one per beat.
`include "assert_macros.svh"

module jts_tok_fifo import jts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_push_n,
    input  t_token      i_tok [MAX_TOKENS],
    input  logic        i_pop,
    output logic        o_room,
    output logic        o_valid,
    output t_token      o_tok
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_token             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W:0]     need;
    logic [CNT_W:0]     limit;

    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    // room for a full burst once this cycle's pop is counted
    assign need   = {1'b0, r_count} + (CNT_W + 1)'(MAX_TOKENS);
    assign limit  = (CNT_W + 1)'(FIFO_DEPTH) + {{CNT_W{1'b0}}, i_pop};
    assign o_room = (need <= limit);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_TOKENS; k++) begin
            if (2'(k) < i_push_n) begin
                r_mem[PTR_W'(r_wr + PTR_W'(k))] <= i_tok[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= PTR_W'(r_wr + PTR_W'(i_push_n));
            r_rd    <= r_rd + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_push_n) - CNT_W'(i_pop);
        end
    end

    `JTS_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(FIFO_DEPTH), "token count above depth")
    `JTS_ASSERT(a_push_room, i_clk, i_rst_n, (i_push_n != 2'd0) |-> o_room, "push without room")
    `JTS_ASSERT(a_drain, i_clk, i_rst_n, (r_count == CNT_W'(1) && i_pop && i_push_n == 2'd0) |=> !o_valid, "queue not empty after last pop")

endmodule

// ===== rtl/core/json_token_scanner.sv =====
// JSON token scanner: byte stream in, token stream out.
//
// Slave side takes one text byte per beat; tlast marks the last byte of a
// document. Master side gives one token per beat: tuser is the token kind,
// tdata holds start, length, row and column, tlast marks the final token
// caused by one input byte.
// Each byte is held in an input register and decoded against the scanner
// state; its zero to three tokens enter a four-entry token queue in the
// cycle of that decode. The first token is valid once the byte has passed
// the input register and been written into the queue.
// Throughput: one byte per cycle while each byte yields at most one token
// and tokens are taken; the output moves one token per cycle, so bursts of
// two or three tokens (delimiter after a word, end of document) queue up.
// The input stalls only when the queue could not take a full burst.
// Reset clears the scanner state, the input register and the queue; a
// document that ends (tlast) also returns the scanner to its reset state.
// When the receiver stalls, tokens back up in the queue and then in the
// input register, and tready drops; nothing is lost.
module json_token_scanner import jts_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] text_byte
    input  logic         i_s_axis_tlast,   // final_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // token_start, token_length, token_row, token_column
    output logic [3:0]   o_m_axis_tuser,   // token_kind
    output logic         o_m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_fin;
    logic       go;
    logic       room;
    logic       pop;
    logic [1:0] push_n;
    t_token     toks [MAX_TOKENS];
    t_token     head;

    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign go              = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_byte <= i_s_axis_tdata;
            r_fin  <= i_s_axis_tlast;
        end
    end

    jts_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_byte   (r_byte),
        .i_fin    (r_fin),
        .o_push_n (push_n),
        .o_tok    (toks)
    );

    jts_tok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_tok    (toks),
        .i_pop    (pop),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .o_tok    (head)
    );

    assign o_m_axis_tdata = {head.column, head.row, head.length, head.start};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

// ===== test/json_token_scanner_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for json_token_scanner: random JSON text checked against a token predictor.
module json_token_scanner_test;
    import jts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;
    localparam int DRAIN_WAIT  = 20;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [3:0] {
        TK_LBRACE, TK_RBRACE, TK_COLON, TK_LBRACKET, TK_RBRACKET, TK_COMMA,
        TK_QUOTED, TK_WORD, TK_NUMBER, TK_FLOAT, TK_END
    } tok_kind_e;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_STR, SCAN_ESC, SCAN_WORD, SCAN_NUM
    } scan_state_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_beat_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = '0;
    logic         i_s_axis_tlast = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;
    logic [3:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    // scanner state as predicted
    scan_state_e  scan_st;
    logic         num_dot;
    logic [31:0]  lit_start;
    logic [31:0]  byte_pos;
    logic [31:0]  row_pos;
    logic [31:0]  col_pos;
    t_token       burst [MAX_TOKENS];
    int           burst_n;

    t_token       token_q [$];
    text_beat_t   text_q [$];
    logic [7:0]   doc_buf [$];
    t_token       head;

    int           queued = 0;
    int           tokens_seen = 0;
    int           send_idle_pct = 19;
    int           recv_idle_pct = 60;
    int           err_count = 0;
    int           cycle_count = 0;

    string        punct_set = "{}[]:,";
    string        hex_set = "0123456789abcdefABCDEF";
    string        alnum_set = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    logic [7:0]   blank_set [6] = '{" ", CH_NL, CH_CR, CH_TAB, CH_VT, CH_FF};

    json_token_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void clear_scan();
        scan_st   = SCAN_IDLE;
        num_dot   = 1'b0;
        lit_start = '0;
        byte_pos  = '0;
        row_pos   = '0;
        col_pos   = '0;
    endfunction

    function automatic void step_pos();
        byte_pos = sat_inc(byte_pos);
        col_pos  = sat_inc(col_pos);
    endfunction

    function automatic void emit(logic [3:0] kind, logic [31:0] start, logic [31:0] len,
                                 logic [31:0] col);
        t_token tk;
        tk.kind   = kind;
        tk.start  = start;
        tk.length = len;
        tk.row    = row_pos;
        tk.column = col;
        tk.last   = 1'b0;
        if (burst_n < MAX_TOKENS) begin
            burst[burst_n] = tk;
            burst_n++;
        end
    endfunction

    function automatic void close_run();
        logic [31:0] len;
        len = byte_pos - lit_start;
        if (scan_st == SCAN_NUM) begin
            emit(num_dot ? TK_FLOAT : TK_NUMBER, lit_start, len, col_pos - len);
        end else begin
            emit(TK_WORD, lit_start, len, col_pos - len);
        end
        scan_st = SCAN_IDLE;
        num_dot = 1'b0;
    endfunction

    function automatic void close_string();
        logic [31:0] len;
        len = byte_pos - lit_start;
        emit(TK_QUOTED, lit_start, len, col_pos - len - 32'd1);
        scan_st = SCAN_IDLE;
    endfunction

    // tokens caused by one text beat, appended to token_q
    function automatic void scan_byte(logic [7:0] ch, logic fin);
        logic taken;
        logic opened;
        taken   = 1'b0;
        opened  = 1'b0;
        burst_n = 0;
        case (scan_st)
            SCAN_WORD: begin
                if (is_digit(ch) || is_alpha(ch)) begin
                    step_pos();
                    taken = 1'b1;
                end else begin
                    close_run();
                end
            end
            SCAN_NUM: begin
                if (is_hex(ch) || ch == "." || ch == "+" || ch == "-") begin
                    if (ch == ".") num_dot = 1'b1;
                    step_pos();
                    taken = 1'b1;
                end else begin
                    close_run();
                end
            end
            SCAN_ESC: begin
                scan_st = SCAN_STR;
                step_pos();
                taken = 1'b1;
            end
            SCAN_STR: begin
                if (ch == CH_NL) row_pos = sat_inc(row_pos);
                if (ch == "\\") begin
                    scan_st = SCAN_ESC;
                end else if (ch == "\"") begin
                    close_string();
                end
                step_pos();
                taken = 1'b1;
            end
            default: ;
        endcase

        if (!taken) begin
            if (ch == "\"") begin
                step_pos();
                lit_start = byte_pos;
                scan_st   = SCAN_STR;
                opened    = 1'b1;
            end else begin
                case (ch)
                    "{": emit(TK_LBRACE, byte_pos, 32'd1, col_pos);
                    "}": emit(TK_RBRACE, byte_pos, 32'd1, col_pos);
                    ":": emit(TK_COLON, byte_pos, 32'd1, col_pos);
                    "[": emit(TK_LBRACKET, byte_pos, 32'd1, col_pos);
                    "]": emit(TK_RBRACKET, byte_pos, 32'd1, col_pos);
                    ",": emit(TK_COMMA, byte_pos, 32'd1, col_pos);
                    " ", CH_TAB, CH_VT, CH_FF, CH_CR: ;
                    CH_NL: begin
                        row_pos = sat_inc(row_pos);
                        col_pos = '0;
                    end
                    default: begin
                        if (is_digit(ch) || ch == "+" || ch == "-") begin
                            lit_start = byte_pos;
                            num_dot   = 1'b0;
                            scan_st   = SCAN_NUM;
                        end else if (is_alpha(ch)) begin
                            lit_start = byte_pos;
                            scan_st   = SCAN_WORD;
                        end else begin
                            // stray byte: empty word at its own offset
                            emit(TK_WORD, byte_pos, 32'd0, col_pos);
                        end
                    end
                endcase
                step_pos();
            end
        end

        if (fin) begin
            if (scan_st == SCAN_WORD || scan_st == SCAN_NUM) begin
                close_run();
            end else if ((scan_st == SCAN_STR || scan_st == SCAN_ESC) && !opened) begin
                close_string();
            end
            emit(TK_END, byte_pos, 32'd0, col_pos);
            clear_scan();
        end

        if (burst_n > 0) burst[burst_n - 1].last = 1'b1;
        for (int i = 0; i < burst_n; i++) token_q.push_back(burst[i]);
    endfunction

    task automatic report_error(string msg);
        if (err_count < PRINT_CAP) $display("[%0t] error: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("token %0d %s: got %0d, expected %0d",
                                   tokens_seen, name, got, want));
        end
    endtask

    task automatic push_byte(logic [7:0] c);
        doc_buf.push_back(c);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic flush_doc();
        text_beat_t bt;
        foreach (doc_buf[i]) begin
            bt.ch  = doc_buf[i];
            bt.fin = (i == doc_buf.size() - 1);
            text_q.push_back(bt);
        end
        queued += doc_buf.size();
        doc_buf.delete();
    endtask

    task automatic add_fragment();
        int n;
        case ($urandom_range(0, 11))
            0, 1: push_byte(punct_set[$urandom_range(0, 5)]);
            2, 3: begin
                push_byte("\"");
                n = $urandom_range(0, 6);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0: begin
                            push_byte("\\");
                            push_byte(8'($urandom_range(32, 126)));
                        end
                        1: push_byte(CH_NL);
                        default: push_byte(8'($urandom_range(32, 126)));
                    endcase
                end
                if ($urandom_range(0, 7) != 0) push_byte("\"");
            end
            4, 5: begin
                case ($urandom_range(0, 5))
                    0: push_byte("-");
                    1: push_byte("+");
                    default: push_byte(8'("0" + $urandom_range(0, 9)));
                endcase
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_byte(".");
                    end else if ($urandom_range(0, 9) == 0) begin
                        push_byte("-");
                    end else begin
                        push_byte(hex_set[$urandom_range(0, 21)]);
                    end
                end
            end
            6, 7: begin
                push_byte(alnum_set[$urandom_range(10, 61)]);
                n = $urandom_range(0, 5);
                repeat (n) push_byte(alnum_set[$urandom_range(0, 61)]);
            end
            8, 9: begin
                n = $urandom_range(1, 3);
                repeat (n) push_byte(blank_set[$urandom_range(0, 5)]);
            end
            10: push_byte(8'($urandom_range(0, 255)));
            default: push_byte("\"");
        endcase
    endtask

    task automatic fill_random(int count);
        int goal;
        int frags;
        goal = queued + count;
        while (queued < goal) begin
            frags = $urandom_range(1, 10);
            repeat (frags) add_fragment();
            flush_doc();
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (text_q.size() != 0 || token_q.size() != 0);
    endtask

    // driver: the front of text_q is the beat on the bus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                scan_byte(i_s_axis_tdata, i_s_axis_tlast);
                void'(text_q.pop_front());
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                i_s_axis_tvalid <= 1'b1;
            end else if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= text_q[0].ch;
                i_s_axis_tlast  <= text_q[0].fin;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (token_q.size() == 0) begin
                    report_error($sformatf("unexpected token kind %0d start %0d",
                                           o_m_axis_tuser, o_m_axis_tdata[31:0]));
                end else begin
                    head = token_q.pop_front();
                    compare_field("kind", 32'(o_m_axis_tuser), 32'(head.kind));
                    compare_field("start", o_m_axis_tdata[31:0], head.start);
                    compare_field("length", o_m_axis_tdata[63:32], head.length);
                    compare_field("row", o_m_axis_tdata[95:64], head.row);
                    compare_field("column", o_m_axis_tdata[127:96], head.column);
                    compare_field("last", 32'(o_m_axis_tlast), 32'(head.last));
                end
                tokens_seen++;
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** json_token_scanner: FAILED **");
            $finish;
        end
    end

    initial begin
        clear_scan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // escaped quote and newline in a string, float, word, all punctuation
        push_text("{\"a\\\"\nb\":+1.f,[w]}");
        flush_doc();
        // stray bytes, whitespace bytes other than space, word closed by the last byte
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_VT);
        push_byte(CH_FF);
        push_byte(CH_CR);
        push_byte(CH_TAB);
        push_byte(CH_NL);
        push_byte("x");
        flush_doc();
        // opening quote as last byte, then an unterminated string
        push_byte("\"");
        flush_doc();
        push_text("\"q");
        flush_doc();

        fill_random(100);
        wait_drained();

        send_idle_pct = 60;
        recv_idle_pct = 19;
        fill_random(100);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(100);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (token_q.size() != 0) begin
            report_error($sformatf("%0d tokens never arrived", token_q.size()));
        end
        if (err_count == 0) begin
            $display("** json_token_scanner: PASSED **");
        end else begin
            $display("** json_token_scanner: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/jts_pkg.sv
rtl/core/jts_scan.sv
rtl/core/jts_tok_fifo.sv
rtl/core/json_token_scanner.sv
test/json_token_scanner_test.sv
